/* hw/rtl/rtnb_pkg.sv */
// Shared types and constants for the radix tree node builder.
// No dependencies.
`default_nettype none
package rtnb_pkg;

    // code memory depth; node and child fields are sized for it
    localparam int MAX_CODES = 1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ_I,
        ST_PROBE_RD,
        ST_PROBE_WAIT,
        ST_PROBE_EVAL,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_NEXT,
        PH_PREV,
        PH_DMIN,
        PH_EXP,
        PH_BIN,
        PH_DNODE,
        PH_SPLIT
    } phase_t;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_BUILD = 1'b1;

endpackage
`default_nettype wire

/* hw/rtl/rtnb_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface rtnb_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rtnb_ram.sv */
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none
module rtnb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/rtnb_lzc.sv */
// Leading-zero count of a code XOR, as a combinational priority scan.
// Depends on nothing.
`default_nettype none
module rtnb_lzc #(
    parameter int W = 64
) (
    input  wire logic [W-1:0]         a,
    input  wire logic [W-1:0]         b,
    output logic      [$clog2(W+1)-1:0] count
);
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0] v;
    always_comb
    begin
        v = a ^ b;
        count = CNT_W'(W);
        for (int k = 0; k < W; k++)
        begin
            if (v[k])
            begin
                count = CNT_W'(W - 1 - k);
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/radix_tree_node_builder.sv */
// Top level of the radix tree node builder: controller, code memory, lzc.
// Depends on rtnb_pkg, rtnb_if, rtnb_ram, rtnb_lzc.
//
// Load requests write one code into the code memory.
// A build request walks the Karras search over the one code memory port:
// code[i] is read once and held, then every probe is a read (ST_PROBE_RD,
// ST_PROBE_WAIT) plus an evaluate state (ST_PROBE_EVAL). Two neighbour
// probes, the dmin probe, about log2(range)+1 exponential probes,
// log2(range) binary probes, one dnode probe and about log2(range)+1 split
// probes make up one node. One request at a time; the result waits in an
// output register until taken.
`default_nettype none
module radix_tree_node_builder #(
    parameter int CODE_BITS = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic [10:0] cfg_wdata,
    rtnb_if.sink       req,
    rtnb_if.source     rsp
);
    localparam int AW = $clog2(rtnb_pkg::MAX_CODES);
    localparam int CW = $clog2(CODE_BITS + 1);
    localparam int SW = AW + 3;   // signed index width with headroom

    logic [10:0] count_reg;
    rtnb_pkg::state_t state_reg, state_next;
    rtnb_pkg::phase_t phase_reg, phase_next;

    logic signed [SW-1:0] i_reg, i_next, n_s;
    logic d_neg_reg, d_neg_next;
    logic signed [CW:0] pa_reg, pa_next, dmin_reg, dmin_next, ref_len;
    logic [SW-1:0] lmax_reg, lmax_next, l_reg, l_next, t_reg, t_next;
    logic [SW-1:0] s_reg, s_next;
    logic [4:0] k_reg, k_next;
    logic [CODE_BITS-1:0] ci_reg, ci_next;
    logic signed [SW-1:0] probe_reg, probe_next;
    logic out_valid_reg, out_valid_next;
    logic [9:0] o_node_reg, o_node_next, o_l_reg, o_l_next, o_r_reg, o_r_next;
    logic [9:0] o_j_reg, o_j_next;
    logic o_ll_reg, o_ll_next, o_rl_reg, o_rl_next, o_err_reg, o_err_next;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [CODE_BITS-1:0] ram_rdata;
    logic [CW-1:0] lz;
    logic signed [CW:0] plen;
    logic probe_ok;

    rtnb_ram #(.WIDTH(CODE_BITS), .DEPTH(rtnb_pkg::MAX_CODES)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr),
        .wdata(req.data.code[CODE_BITS-1:0]), .rdata(ram_rdata)
    );

    rtnb_lzc #(.W(CODE_BITS)) u_lzc (.a(ci_reg), .b(ram_rdata), .count(lz));

    always_comb
    begin
        if (count_reg > 11'(rtnb_pkg::MAX_CODES))
        begin
            n_s = SW'(rtnb_pkg::MAX_CODES);
        end
        else
        begin
            n_s = SW'(count_reg);
        end
    end

    assign probe_ok = (probe_reg >= 0) && (probe_reg < n_s);
    assign plen = probe_ok ? $signed({1'b0, lz}) : (CW+1)'(-1);

    // probe target = i +/- offset
    function automatic logic signed [SW-1:0] tgt(input logic signed [SW-1:0] i,
                                                 input logic [SW-1:0] off,
                                                 input logic neg);
        logic signed [SW-1:0] o;
        o = $signed(off);
        return neg ? i - o : i + o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 11'd1;
            state_reg     <= rtnb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        i_reg     <= i_next;
        d_neg_reg <= d_neg_next;
        pa_reg    <= pa_next;
        dmin_reg  <= dmin_next;
        lmax_reg  <= lmax_next;
        l_reg     <= l_next;
        t_reg     <= t_next;
        s_reg     <= s_next;
        k_reg     <= k_next;
        ci_reg    <= ci_next;
        probe_reg <= probe_next;
        o_node_reg <= o_node_next;
        o_l_reg   <= o_l_next;
        o_r_reg   <= o_r_next;
        o_j_reg   <= o_j_next;
        o_ll_reg  <= o_ll_next;
        o_rl_reg  <= o_rl_next;
        o_err_reg <= o_err_next;
    end

    assign req.ready = (state_reg == rtnb_pkg::ST_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    always_comb
    begin
        rsp.data.node_index    = o_node_reg;
        rsp.data.left_child    = o_l_reg;
        rsp.data.left_is_leaf  = o_ll_reg;
        rsp.data.right_child   = o_r_reg;
        rsp.data.right_is_leaf = o_rl_reg;
        rsp.data.range_end     = o_j_reg;
        rsp.data.error         = o_err_reg;
    end

    always_comb
    begin
        logic signed [SW-1:0] j, g, lo, hi;
        logic [SW-1:0] tn;
        logic gt;
        state_next = state_reg;
        phase_next = phase_reg;
        i_next = i_reg; d_neg_next = d_neg_reg; pa_next = pa_reg;
        dmin_next = dmin_reg; lmax_next = lmax_reg; l_next = l_reg;
        t_next = t_reg; s_next = s_reg; k_next = k_reg; ci_next = ci_reg;
        probe_next = probe_reg; out_valid_next = out_valid_reg;
        o_node_next = o_node_reg; o_l_next = o_l_reg; o_r_next = o_r_reg;
        o_j_next = o_j_reg; o_ll_next = o_ll_reg; o_rl_next = o_rl_reg;
        o_err_next = o_err_reg;
        ram_we = 1'b0;
        ram_addr = probe_reg[AW-1:0];
        j = '0; g = '0; lo = '0; hi = '0; tn = '0;
        ref_len = (phase_reg == rtnb_pkg::PH_SPLIT) ? pa_reg : dmin_reg;
        gt = plen > ref_len;
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            rtnb_pkg::ST_IDLE:
            begin
                ram_addr = req.data.index[AW-1:0];
                if (req.valid && req.ready)
                begin
                    if (req.data.action == rtnb_pkg::ACT_LOAD)
                    begin
                        ram_we = (32'(req.data.index) < rtnb_pkg::MAX_CODES);
                    end
                    else
                    begin
                        i_next = SW'(req.data.index);
                        o_node_next = req.data.index;
                        o_l_next = '0; o_r_next = '0; o_j_next = '0;
                        o_ll_next = 1'b0; o_rl_next = 1'b0; o_err_next = 1'b1;
                        state_next = rtnb_pkg::ST_CHECK;
                    end
                end
            end
            rtnb_pkg::ST_CHECK:
            begin
                ram_addr = i_reg[AW-1:0];
                if (n_s < 2 || i_reg >= n_s - 1)
                begin
                    out_valid_next = 1'b1;
                    state_next = rtnb_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rtnb_pkg::ST_READ_I;
                end
            end
            rtnb_pkg::ST_READ_I:
            begin
                ci_next = ram_rdata;
                probe_next = SW'(i_reg + 1);
                phase_next = rtnb_pkg::PH_NEXT;
                state_next = rtnb_pkg::ST_PROBE_RD;
            end
            rtnb_pkg::ST_PROBE_RD:
            begin
                state_next = rtnb_pkg::ST_PROBE_WAIT;
            end
            rtnb_pkg::ST_PROBE_WAIT:
            begin
                state_next = rtnb_pkg::ST_PROBE_EVAL;
            end
            rtnb_pkg::ST_PROBE_EVAL:
            begin
                state_next = rtnb_pkg::ST_PROBE_RD;
                unique case (phase_reg)
                    rtnb_pkg::PH_NEXT:
                    begin
                        pa_next = plen;
                        probe_next = SW'(i_reg - 1);
                        phase_next = rtnb_pkg::PH_PREV;
                    end
                    rtnb_pkg::PH_PREV:
                    begin
                        if (pa_reg == plen)
                        begin
                            out_valid_next = 1'b1;
                            state_next = rtnb_pkg::ST_IDLE;
                        end
                        else
                        begin
                            d_neg_next = pa_reg < plen;
                            probe_next = (pa_reg < plen) ? SW'(i_reg + 1) : SW'(i_reg - 1);
                            phase_next = rtnb_pkg::PH_DMIN;
                        end
                    end
                    rtnb_pkg::PH_DMIN:
                    begin
                        dmin_next = plen;
                        lmax_next = SW'(2);
                        probe_next = tgt(i_reg, SW'(2), d_neg_reg);
                        phase_next = rtnb_pkg::PH_EXP;
                    end
                    rtnb_pkg::PH_EXP:
                    begin
                        if (gt)
                        begin
                            lmax_next = lmax_reg << 1;
                            probe_next = tgt(i_reg, lmax_reg << 1, d_neg_reg);
                        end
                        else
                        begin
                            l_next = '0;
                            t_next = lmax_reg >> 1;
                            probe_next = tgt(i_reg, lmax_reg >> 1, d_neg_reg);
                            phase_next = rtnb_pkg::PH_BIN;
                        end
                    end
                    rtnb_pkg::PH_BIN:
                    begin
                        l_next = gt ? l_reg + t_reg : l_reg;
                        tn = t_reg >> 1;
                        t_next = tn;
                        if (tn != 0)
                        begin
                            probe_next = tgt(i_reg, l_next + tn, d_neg_reg);
                        end
                        else
                        begin
                            probe_next = tgt(i_reg, l_next, d_neg_reg);
                            phase_next = rtnb_pkg::PH_DNODE;
                        end
                    end
                    rtnb_pkg::PH_DNODE:
                    begin
                        pa_next = plen;
                        s_next = '0;
                        k_next = 5'd1;
                        t_next = (l_reg + SW'(1)) >> 1;
                        probe_next = tgt(i_reg, (l_reg + SW'(1)) >> 1, d_neg_reg);
                        phase_next = rtnb_pkg::PH_SPLIT;
                    end
                    rtnb_pkg::PH_SPLIT:
                    begin
                        s_next = gt ? s_reg + t_reg : s_reg;
                        if (t_reg <= 1)
                        begin
                            j = tgt(i_reg, l_reg, d_neg_reg);
                            g = SW'(tgt(i_reg, s_next, d_neg_reg) - (d_neg_reg ? 1 : 0));
                            lo = (i_reg < j) ? i_reg : j;
                            hi = (i_reg > j) ? i_reg : j;
                            o_l_next = g[9:0];
                            o_r_next = 10'(g + 1);
                            o_ll_next = (lo == g);
                            o_rl_next = (hi == g + 1);
                            o_j_next = j[9:0];
                            o_err_next = 1'b0;
                            out_valid_next = 1'b1;
                            state_next = rtnb_pkg::ST_IDLE;
                        end
                        else
                        begin
                            k_next = k_reg + 5'd1;
                            tn = (l_reg + (SW'(1) << (k_reg + 5'd1)) - SW'(1))
                                 >> (k_reg + 5'd1);
                            t_next = tn;
                            probe_next = tgt(i_reg, s_next + tn, d_neg_reg);
                        end
                    end
                    default:
                    begin
                        state_next = rtnb_pkg::ST_IDLE;
                    end
                endcase
            end
            rtnb_pkg::ST_DONE:
            begin
                state_next = rtnb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rtnb_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire
